// ===== rtl/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared constants, types and address helpers for the text terminal buffer.
// ----------------------------------------------------------------------------
package ttcb_pkg;

	// screen geometry
	localparam int ROWS      = 25;
	localparam int COLUMNS   = 80;
	localparam int DEPTH     = ROWS * COLUMNS;
	localparam int AW        = $clog2(DEPTH);
	localparam int RW        = $clog2(ROWS);
	localparam int CW        = $clog2(COLUMNS + 1);
	localparam int TAB_SPACES = 4;
	localparam int TW        = $clog2(TAB_SPACES);

	// field widths on the stream ports
	localparam int KIND_W = 2;
	localparam int CODE_W = 8;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;

	// character codes
	localparam logic [CODE_W-1:0] CODE_NULL      = 8'd0;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;
	localparam logic [CODE_W-1:0] GLYPH_CURSOR   = 8'd62;

	// command kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_TOGGLE = 2'd3
	} kind_t;

	// character classes of a write
	typedef enum logic [2:0] {
		CC_NULL,
		CC_NEWLINE,
		CC_TAB,
		CC_BACKSPACE,
		CC_PRINT
	} char_class_t;

	// cursor update operations
	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_HOME,
		CUR_WRAP,
		CUR_INC_COL,
		CUR_BACK
	} cur_op_t;

	// memory write data select
	typedef enum logic [1:0] {
		WD_ZERO,
		WD_SPACE,
		WD_CODE,
		WD_GLYPH
	} wdata_sel_t;

	// address source for the cell address register
	typedef enum logic {
		ADDR_CURSOR,
		ADDR_READ
	} addr_src_t;

	// controller states
	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_PUT_CHECK,
		ST_PUT_ADDR,
		ST_PUT_WRITE,
		ST_SCROLL,
		ST_CLEAR,
		ST_BS_ADDR1,
		ST_BS_WRITE1,
		ST_BS_STEP,
		ST_BS_ADDR2,
		ST_BS_WRITE2,
		ST_TOG_ADDR,
		ST_TOG_WRITE,
		ST_RD_ADDR,
		ST_RD_MEM,
		ST_RD_DATA,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       item_load;
		cur_op_t    cur_op;
		logic       scroll_start;
		logic       clear_start;
		logic       sweep_step;
		logic       addr_load;
		addr_src_t  addr_src;
		logic       mem_wr;
		wdata_sel_t wdata_sel;
		logic       mem_rd;
		logic       cell_load;
		logic       tab_step;
		logic       blink_flip;
	} ttcb_cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t       kind;
		char_class_t char_class;
		logic        col_full;
		logic        col_zero;
		logic        row_zero;
		logic        last_row;
		logic        tab_last;
		logic        sweep_last;
		logic        rd_in_range;
	} ttcb_status_t;

	// physical row of a screen row under the current scroll base
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
			input logic [RW-1:0] row);
		logic [RW:0] sum;
		sum = {1'b0, base} + {1'b0, row};
		if (sum >= (RW+1)'(ROWS))
			sum = sum - (RW+1)'(ROWS);
		return sum[RW-1:0];
	endfunction

	// linear cell address of a physical row and column
	function automatic logic [AW-1:0] row_addr(input logic [RW-1:0] prow,
			input logic [CW-1:0] col);
		return AW'(prow) * AW'(COLUMNS) + AW'(col);
	endfunction

endpackage

// ===== rtl/ttcb_datapath.sv =====
// ----------------------------------------------------------------------------
// ttcb_datapath
// Cursor, scroll base, blink flag, sweep counter and the cell memory.
// ----------------------------------------------------------------------------
module ttcb_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ttcb_pkg::ttcb_cmd_t           cmd,
	output ttcb_pkg::ttcb_status_t        status,
	input  logic [ttcb_pkg::KIND_W-1:0]   in_kind,
	input  logic [ttcb_pkg::CODE_W-1:0]   in_char_code,
	input  logic [ttcb_pkg::RROW_W-1:0]   in_read_row,
	input  logic [ttcb_pkg::RCOL_W-1:0]   in_read_col,
	output logic [ttcb_pkg::CODE_W-1:0]   cell_char,
	output logic [ttcb_pkg::RROW_W-1:0]   cursor_row,
	output logic [ttcb_pkg::RCOL_W-1:0]   cursor_col,
	output logic                          scrolled
);
	import ttcb_pkg::*;

	// captured item
	logic [KIND_W-1:0] kind_q;
	logic [CODE_W-1:0] code_q;
	logic [RROW_W-1:0] rrow_q;
	logic [RCOL_W-1:0] rcol_q;

	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     base_q;
	logic              blink_q;
	logic              scrolled_q;
	logic [TW-1:0]     tab_cnt_q;
	logic [AW-1:0]     sweep_addr_q;
	logic [AW-1:0]     sweep_cnt_q;
	logic [AW-1:0]     addr_q;
	logic [CODE_W-1:0] rdata_q;
	logic [CODE_W-1:0] cell_q;

	logic [CODE_W-1:0] mem [DEPTH];

	logic              rd_in_range;
	logic [AW-1:0]     addr_d;
	logic [CODE_W-1:0] wdata;
	logic [AW-1:0]     wr_addr;
	logic              wr_en;
	char_class_t       cls;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q <= in_kind;
			code_q <= in_char_code;
			rrow_q <= in_read_row;
			rcol_q <= in_read_col;
		end
	end

	// character class of the captured code
	always_comb begin
		case (code_q)
			CODE_NULL:      cls = CC_NULL;
			CODE_NEWLINE:   cls = CC_NEWLINE;
			CODE_TAB:       cls = CC_TAB;
			CODE_BACKSPACE: cls = CC_BACKSPACE;
			default:        cls = CC_PRINT;
		endcase
	end

	assign rd_in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);

	// status to the controller
	always_comb begin
		status.kind        = kind_t'(kind_q);
		status.char_class  = cls;
		status.col_full    = (col_q == CW'(COLUMNS));
		status.col_zero    = (col_q == '0);
		status.row_zero    = (row_q == '0);
		status.last_row    = (row_q == RW'(ROWS - 1));
		status.tab_last    = (tab_cnt_q == TW'(TAB_SPACES - 1));
		status.sweep_last  = (sweep_cnt_q == '0);
		status.rd_in_range = rd_in_range;
	end

	// cursor, scroll base, blink and per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			base_q     <= '0;
			blink_q    <= 1'b0;
			scrolled_q <= 1'b0;
			tab_cnt_q  <= '0;
		end else begin
			case (cmd.cur_op)
				CUR_HOME: begin
					row_q <= '0;
					col_q <= '0;
				end
				CUR_WRAP: begin
					col_q <= '0;
					if (row_q != RW'(ROWS - 1))
						row_q <= row_q + 1'b1;
				end
				CUR_INC_COL: begin
					col_q <= col_q + 1'b1;
				end
				CUR_BACK: begin
					if (col_q != '0) begin
						col_q <= col_q - 1'b1;
					end else begin
						row_q <= row_q - 1'b1;
						col_q <= CW'(COLUMNS - 1);
					end
				end
				default: begin
				end
			endcase
			if (cmd.item_load) begin
				scrolled_q <= 1'b0;
				tab_cnt_q  <= '0;
			end
			if (cmd.tab_step)
				tab_cnt_q <= tab_cnt_q + 1'b1;
			if (cmd.scroll_start) begin
				scrolled_q <= 1'b1;
				base_q     <= (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;
			end
			if (cmd.blink_flip)
				blink_q <= ~blink_q;
		end
	end

	// zero sweep over one row or the whole screen, armed for the reset pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_cnt_q  <= AW'(DEPTH - 1);
		end else if (cmd.scroll_start) begin
			sweep_addr_q <= row_addr(base_q, '0);
			sweep_cnt_q  <= AW'(COLUMNS - 1);
		end else if (cmd.clear_start) begin
			sweep_addr_q <= '0;
			sweep_cnt_q  <= AW'(DEPTH - 1);
		end else if (cmd.sweep_step) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
			sweep_cnt_q  <= sweep_cnt_q - 1'b1;
		end
	end

	// cell address register
	always_comb begin
		if (cmd.addr_src == ADDR_READ)
			addr_d = row_addr(phys_row(base_q, RW'(rrow_q)), CW'(rcol_q));
		else
			addr_d = row_addr(phys_row(base_q, row_q), col_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_load)
			addr_q <= addr_d;
	end

	// write data select
	always_comb begin
		case (cmd.wdata_sel)
			WD_SPACE: wdata = CODE_SPACE;
			WD_CODE:  wdata = code_q;
			WD_GLYPH: wdata = blink_q ? GLYPH_CURSOR : CODE_NULL;
			default:  wdata = CODE_NULL;
		endcase
	end

	assign wr_en   = cmd.mem_wr | cmd.sweep_step;
	assign wr_addr = cmd.sweep_step ? sweep_addr_q : addr_q;

	// cell memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= cmd.sweep_step ? CODE_NULL : wdata;
		if (cmd.mem_rd)
			rdata_q <= mem[addr_q];
	end

	// read result
	always_ff @(posedge clk) begin
		if (cmd.item_load)
			cell_q <= '0;
		else if (cmd.cell_load)
			cell_q <= rdata_q;
	end

	assign cell_char  = cell_q;
	assign cursor_row = RROW_W'(row_q);
	assign cursor_col = RCOL_W'(col_q);
	assign scrolled   = scrolled_q;

endmodule

// ===== rtl/ttcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Sequencer that steps each command through the datapath one action a cycle,
// holding in its finish state until the output register is free.
module ttcb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   out_free,
	input  ttcb_pkg::ttcb_status_t status,
	output ttcb_pkg::ttcb_cmd_t    cmd,
	output logic                   ready,
	output logic                   done
);
	import ttcb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   scroll_put_q;
	logic   scroll_put_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			scroll_put_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			scroll_put_q <= scroll_put_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		scroll_put_d = scroll_put_q;
		cmd          = '0;
		cmd.cur_op   = CUR_HOLD;
		cmd.addr_src = ADDR_CURSOR;
		cmd.wdata_sel = WD_ZERO;
		ready        = 1'b0;
		done         = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				ready = 1'b1;
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.kind)
					KIND_WRITE: begin
						case (status.char_class)
							CC_NULL: state_d = ST_FINISH;
							CC_NEWLINE: begin
								cmd.cur_op = CUR_WRAP;
								if (status.last_row) begin
									cmd.scroll_start = 1'b1;
									scroll_put_d     = 1'b0;
									state_d          = ST_SCROLL;
								end else begin
									state_d = ST_FINISH;
								end
							end
							CC_BACKSPACE: begin
								state_d = status.col_full ? ST_BS_STEP : ST_BS_ADDR1;
							end
							default: state_d = ST_PUT_CHECK;
						endcase
					end
					KIND_READ: begin
						state_d = status.rd_in_range ? ST_RD_ADDR : ST_FINISH;
					end
					KIND_CLEAR: begin
						cmd.clear_start = 1'b1;
						cmd.cur_op      = CUR_HOME;
						state_d         = ST_CLEAR;
					end
					default: begin
						cmd.blink_flip = 1'b1;
						state_d = status.col_full ? ST_FINISH : ST_TOG_ADDR;
					end
				endcase
			end
			// wrap a full line before storing
			ST_PUT_CHECK: begin
				if (status.col_full) begin
					cmd.cur_op = CUR_WRAP;
					if (status.last_row) begin
						cmd.scroll_start = 1'b1;
						scroll_put_d     = 1'b1;
						state_d          = ST_SCROLL;
					end else begin
						state_d = ST_PUT_ADDR;
					end
				end else begin
					state_d = ST_PUT_ADDR;
				end
			end
			ST_PUT_ADDR: begin
				cmd.addr_load = 1'b1;
				state_d       = ST_PUT_WRITE;
			end
			ST_PUT_WRITE: begin
				cmd.mem_wr    = 1'b1;
				cmd.wdata_sel = (status.char_class == CC_TAB) ? WD_SPACE : WD_CODE;
				cmd.cur_op    = CUR_INC_COL;
				cmd.tab_step  = 1'b1;
				if (status.char_class == CC_TAB && !status.tab_last)
					state_d = ST_PUT_CHECK;
				else
					state_d = ST_FINISH;
			end
			// blank the new bottom row
			ST_SCROLL: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last)
					state_d = scroll_put_q ? ST_PUT_ADDR : ST_FINISH;
			end
			ST_CLEAR: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last)
					state_d = ST_FINISH;
			end
			// backspace: blank under cursor unless the column is full, step back, blank again (no step at home)
			ST_BS_ADDR1: begin
				cmd.addr_load = 1'b1;
				state_d       = ST_BS_WRITE1;
			end
			ST_BS_WRITE1: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_BS_STEP;
			end
			ST_BS_STEP: begin
				if (!status.col_zero || !status.row_zero) begin
					cmd.cur_op = CUR_BACK;
					state_d    = ST_BS_ADDR2;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_BS_ADDR2: begin
				cmd.addr_load = 1'b1;
				state_d       = ST_BS_WRITE2;
			end
			ST_BS_WRITE2: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_FINISH;
			end
			// cursor glyph
			ST_TOG_ADDR: begin
				cmd.addr_load = 1'b1;
				state_d       = ST_TOG_WRITE;
			end
			ST_TOG_WRITE: begin
				cmd.mem_wr    = 1'b1;
				cmd.wdata_sel = WD_GLYPH;
				state_d       = ST_FINISH;
			end
			// cell read
			ST_RD_ADDR: begin
				cmd.addr_load = 1'b1;
				cmd.addr_src  = ADDR_READ;
				state_d       = ST_RD_MEM;
			end
			ST_RD_MEM: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				cmd.cell_load = 1'b1;
				state_d       = ST_FINISH;
			end
			// hand the result to the output register
			ST_FINISH: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/text_terminal_char_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// text_terminal_char_buffer_unit
// Character-cell text screen with cursor, scrolling, read, clear and blink.
// ----------------------------------------------------------------------------
// Items are handled one at a time by a sequencer over a single-port cell
// memory, one memory access per cycle. A scroll also blanks the new bottom
// row, all 80 of its cells, since rows live in a circular buffer and only
// the bottom row is rewritten; a clear blanks every cell (2000). After reset
// the block runs a clearing pass over all 2000 cells before it accepts the
// first word. The result sits in an output register, so the next word is
// accepted while it waits to be taken.
module text_terminal_char_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // cell_char[7:0], cursor_row[12:8], cursor_col[19:13],
	                              // scrolled[20]
);
	import ttcb_pkg::*;

	ttcb_cmd_t    cmd;
	ttcb_status_t status;
	logic         ready;
	logic         done;
	logic         out_free;
	logic         m_tvalid_q;
	logic [23:0]  m_tdata_q;

	logic [CODE_W-1:0] cell_char;
	logic [RROW_W-1:0] cursor_row;
	logic [RCOL_W-1:0] cursor_col;
	logic              scrolled;

	assign out_free = ~m_tvalid_q | m_tready;
	assign s_tready = ready;

	ttcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.ready    (ready),
		.done     (done)
	);

	ttcb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_kind      (s_tuser),
		.in_char_code (s_tdata[7:0]),
		.in_read_row  (s_tdata[12:8]),
		.in_read_col  (s_tdata[19:13]),
		.cell_char    (cell_char),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.scrolled     (scrolled)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			m_tdata_q <= {3'b000, scrolled, cursor_col, cursor_row, cell_char};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text terminal character buffer. A directed
// table covers the corner cases of writes, reads, clear and cursor toggle;
// random command sequences follow. Every result word is compared against a
// behavioral screen model kept inside the bench, or against the typed-in result
// of its directed table row. Both stream sides idle at random, and one long
// output stall fills the block up.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ttcb_pkg::*;

	// one command word and one result word
	typedef struct {
		kind_t           kind;
		logic [7:0]      code;
		logic [4:0]      rrow;
		logic [6:0]      rcol;
	} cmd_t;

	typedef struct packed {
		logic [7:0] cell_code;
		logic [4:0] row;
		logic [6:0] col;
		logic       scrolled;
	} screen_res_t;

	// directed table row, with an optional typed-in result
	typedef struct {
		cmd_t        cmd;
		bit          typed;
		screen_res_t res;
	} table_row_t;

	localparam int RAND_ITEMS = 1250;
	localparam int HOLD_OFF_CYCLES = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	// screen model state
	logic [7:0]  screen_cells [DEPTH];
	int          pos_row;
	int          pos_col;
	bit          cursor_shown;
	bit          scrolled_now;

	screen_res_t expected_results [$];
	table_row_t  directed_rows [$];
	int          err_count = 0;
	int          words_sent = 0;
	int          results_seen = 0;
	int          burst_left = 0;

	text_terminal_char_buffer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// screen model: scroll up one row, blank the bottom row
	function automatic void screen_scroll();
		for (int i = 0; i < DEPTH - COLUMNS; i++)
			screen_cells[i] = screen_cells[i + COLUMNS];
		for (int i = DEPTH - COLUMNS; i < DEPTH; i++)
			screen_cells[i] = 8'd0;
		scrolled_now = 1'b1;
	endfunction

	function automatic void screen_newline();
		pos_col = 0;
		if (pos_row >= ROWS - 1)
			screen_scroll();
		else
			pos_row++;
	endfunction

	function automatic void screen_blank(int r, int c);
		if (r < ROWS && c < COLUMNS)
			screen_cells[r * COLUMNS + c] = 8'd0;
	endfunction

	function automatic void screen_put(logic [7:0] code);
		if (pos_col >= COLUMNS)
			screen_newline();
		screen_cells[pos_row * COLUMNS + pos_col] = code;
		pos_col++;
	endfunction

	function automatic void screen_write(logic [7:0] code);
		if (code == CODE_NULL) begin
			return;
		end else if (code == CODE_NEWLINE) begin
			screen_newline();
		end else if (code == CODE_TAB) begin
			for (int i = 0; i < TAB_SPACES; i++)
				screen_put(CODE_SPACE);
		end else if (code == CODE_BACKSPACE) begin
			// at full column the cell under the cursor does not exist
			if (pos_col < COLUMNS)
				screen_blank(pos_row, pos_col);
			if (pos_col >= 1) begin
				pos_col--;
				screen_blank(pos_row, pos_col);
			end else if (pos_row >= 1) begin
				pos_row--;
				pos_col = COLUMNS - 1;
				screen_blank(pos_row, pos_col);
			end
		end else begin
			screen_put(code);
		end
	endfunction

	// screen model: apply one command, return its result word
	function automatic screen_res_t screen_step(cmd_t c);
		screen_res_t r;
		scrolled_now = 1'b0;
		r.cell_code = 8'd0;
		case (c.kind)
			KIND_WRITE: begin
				screen_write(c.code);
			end
			KIND_READ: begin
				if (int'(c.rrow) < ROWS && int'(c.rcol) < COLUMNS)
					r.cell_code = screen_cells[int'(c.rrow) * COLUMNS + int'(c.rcol)];
			end
			KIND_CLEAR: begin
				foreach (screen_cells[i])
					screen_cells[i] = 8'd0;
				pos_row = 0;
				pos_col = 0;
			end
			default: begin
				// no cell is written while the column is full
				cursor_shown = !cursor_shown;
				if (pos_col < COLUMNS)
					screen_cells[pos_row * COLUMNS + pos_col] =
						cursor_shown ? GLYPH_CURSOR : CODE_NULL;
			end
		endcase
		r.row = 5'(pos_row);
		r.col = 7'(pos_col);
		r.scrolled = scrolled_now;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
		err_count++;
	endtask

	// send one word with burst/gap idling; called just after a falling edge
	task automatic send_cmd(cmd_t c, bit typed, screen_res_t typed_res);
		screen_res_t predicted;
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.kind;
		s_tdata  <= {4'b0, c.rcol, c.rrow, c.code};
		do @(posedge clk); while (!s_tready);
		predicted = screen_step(c);
		expected_results = {expected_results, (typed ? typed_res : predicted)};
		words_sent++;
		@(negedge clk);
	endtask

	// random command with random (ignored) read coordinates
	task automatic send_rand(kind_t k, logic [7:0] code);
		cmd_t c;
		screen_res_t none;
		none = '0;
		c.kind = k;
		c.code = code;
		c.rrow = 5'($urandom);
		c.rcol = 7'($urandom);
		send_cmd(c, 1'b0, none);
	endtask

	task automatic send_read(bit in_range);
		cmd_t c;
		screen_res_t none;
		none = '0;
		c.kind = KIND_READ;
		c.code = 8'($urandom);
		if (in_range) begin
			c.rrow = 5'($urandom_range(0, ROWS - 1));
			c.rcol = 7'($urandom_range(0, COLUMNS - 1));
		end else begin
			c.rrow = 5'($urandom);
			c.rcol = 7'($urandom);
		end
		send_cmd(c, 1'b0, none);
	endtask

	function automatic logic [7:0] pick_printable();
		logic [7:0] code;
		do code = 8'($urandom_range(1, 255));
		while (code == CODE_BACKSPACE || code == CODE_TAB || code == CODE_NEWLINE);
		return code;
	endfunction

	function automatic void add_row(kind_t k, logic [7:0] code, logic [4:0] rr,
			logic [6:0] rc, bit typed, logic [7:0] cell_code, logic [4:0] row,
			logic [6:0] col, logic scr);
		table_row_t t;
		t.cmd.kind = k;
		t.cmd.code = code;
		t.cmd.rrow = rr;
		t.cmd.rcol = rc;
		t.typed = typed;
		t.res.cell_code = cell_code;
		t.res.row = row;
		t.res.col = col;
		t.res.scrolled = scr;
		directed_rows = {directed_rows, t};
	endfunction

	// result checker
	always @(posedge clk) begin
		screen_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word, tdata", int'(m_tdata), -1);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[7:0] !== want.cell_code)
					report_mismatch("cell_char", int'(m_tdata[7:0]), int'(want.cell_code));
				if (m_tdata[12:8] !== want.row)
					report_mismatch("cursor_row", int'(m_tdata[12:8]), int'(want.row));
				if (m_tdata[19:13] !== want.col)
					report_mismatch("cursor_col", int'(m_tdata[19:13]), int'(want.col));
				if (m_tdata[20] !== want.scrolled)
					report_mismatch("scrolled", int'(m_tdata[20]), int'(want.scrolled));
			end
			results_seen++;
		end
	end

	// receiver: stall pattern changes from span to span, one long hold-off
	initial begin
		int mode;
		int span;
		int tick;
		bit held;
		m_tready = 1'b0;
		held = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(64, 256);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (!held && results_seen >= 400) begin
					held = 1'b1;
					m_tready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 9) < 7);
					2: m_tready <= ($urandom_range(0, 9) < 3);
					default: m_tready <= (tick % 5) != 0;
				endcase
			end
		end
	end

	// run limit
	initial begin
		#30_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// reset, directed table, random sequences, drain
	initial begin
		int pick;
		int len;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		foreach (screen_cells[i])
			screen_cells[i] = 8'd0;
		pos_row = 0;
		pos_col = 0;
		cursor_shown = 1'b0;
		scrolled_now = 1'b0;

		// reads after reset, extremes, glyph toggle, specials at home and at full column
		add_row(KIND_READ,   8'd0,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd255, 5'd31, 7'd127, 1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd0,   5'd24, 7'd79,  1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_TOGGLE, 8'd0,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd0,   5'd0,  7'd0,   1, 8'd62, 5'd0, 7'd0,  1'b0);
		add_row(KIND_TOGGLE, 8'd255, 5'd31, 7'd127, 1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd0,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd8,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd65,  5'd31, 7'd127, 1, 8'd0,  5'd0, 7'd1,  1'b0);
		add_row(KIND_WRITE,  8'd255, 5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd2,  1'b0);
		add_row(KIND_WRITE,  8'd9,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd6,  1'b0);
		add_row(KIND_WRITE,  8'd8,   5'd0,  7'd0,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd0,   5'd0,  7'd5,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd0,   5'd0,  7'd1,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd10,  5'd0,  7'd0,   1, 8'd0,  5'd1, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd8,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd79, 1'b0);
		add_row(KIND_WRITE,  8'd120, 5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd80, 1'b0);
		add_row(KIND_WRITE,  8'd8,   5'd0,  7'd0,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd121, 5'd0,  7'd0,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_TOGGLE, 8'd0,   5'd0,  7'd0,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd122, 5'd0,  7'd0,   0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd0,   5'd0,  7'd79,  0, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_CLEAR,  8'd0,   5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_READ,   8'd0,   5'd1,  7'd0,   1, 8'd0,  5'd0, 7'd0,  1'b0);
		add_row(KIND_WRITE,  8'd11,  5'd0,  7'd0,   1, 8'd0,  5'd0, 7'd1,  1'b0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);

		// random command sequences, mostly text that wraps and scrolls
		while (words_sent < RAND_ITEMS + directed_rows.size()) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				len = $urandom_range(1, 100);
				repeat (len) begin
					case ($urandom_range(0, 19))
						0: send_rand(KIND_WRITE, CODE_TAB);
						1: send_rand(KIND_WRITE, CODE_NEWLINE);
						2: send_rand(KIND_WRITE, CODE_BACKSPACE);
						default: send_rand(KIND_WRITE, pick_printable());
					endcase
				end
				// specials right where the column may be full
				case ($urandom_range(0, 3))
					0: send_rand(KIND_WRITE, CODE_BACKSPACE);
					1: send_rand(KIND_TOGGLE, 8'($urandom));
					2: send_rand(KIND_WRITE, CODE_TAB);
					default: send_read(1'b1);
				endcase
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 30))
					send_rand(KIND_WRITE, CODE_NEWLINE);
			end else if (pick < 65) begin
				repeat ($urandom_range(1, 90))
					send_rand(KIND_WRITE, CODE_BACKSPACE);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 12))
					send_read($urandom_range(0, 3) != 0);
			end else if (pick < 89) begin
				repeat ($urandom_range(1, 4))
					send_rand(KIND_TOGGLE, 8'($urandom));
			end else if (pick < 98) begin
				// noise: any kind but clear, any field values
				repeat ($urandom_range(1, 10)) begin
					case ($urandom_range(0, 2))
						0: send_rand(KIND_WRITE, 8'($urandom));
						1: send_read(1'b0);
						default: send_rand(KIND_TOGGLE, 8'($urandom));
					endcase
				end
			end else begin
				send_rand(KIND_CLEAR, 8'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		// drain, then keep watching for stray words
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
